/* rtl/scdt_pkg.sv */
// shared widths, constants, codes and types of the scan count on-delay timer
// no dependencies; every other file of the block imports it
package scdt_pkg;

    localparam int PRESET_W = 23;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 32;
    localparam int END_W    = COUNT_W + 1;

    // serial units: divider takes a 33 bit dividend, multiplier a 33 bit multiplier
    localparam int DIVD_W    = END_W;
    localparam int MULT_W    = END_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int MUL_STEPS = MULT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000);
    localparam logic [PERIOD_W-1:0] US_PER_MS    = PERIOD_W'(1000);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_PRESET = 1'b0,
        REG_PERIOD = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TICKS,
        ST_MUL,
        ST_CHK,
        ST_DIVMS,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // milliseconds to microseconds, modulo 2^33
    function automatic logic [END_W-1:0] ms_to_us(input logic [END_W-1:0] ms);
        return ms * END_W'(US_PER_MS);
    endfunction

endpackage

/* rtl/scdt_if.sv */
// valid/ready channel interfaces for input scans and timer results
// depends on scdt_pkg for field widths
interface scdt_in_if;
    import scdt_pkg::*;
    logic               valid;
    logic               ready;
    logic               enable;
    logic [COUNT_W-1:0] scan_count;

    modport source (output valid, output enable, output scan_count, input ready);
    modport sink   (input valid, input enable, input scan_count, output ready);
endinterface

interface scdt_out_if;
    import scdt_pkg::*;
    logic                valid;
    logic                ready;
    logic                done_res;
    logic [PRESET_W-1:0] elapsed_ms;

    modport source (output valid, output done_res, output elapsed_ms, input ready);
    modport sink   (input valid, input done_res, input elapsed_ms, output ready);
endinterface

/* rtl/scdt_apb.sv */
// apb register file: preset in ms and scan period in us
// depends on scdt_pkg
module scdt_apb (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [scdt_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [scdt_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic [scdt_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic [scdt_pkg::PRESET_W-1:0]    o_preset,
    output logic [scdt_pkg::PERIOD_W-1:0]    o_period
);
    import scdt_pkg::*;

    logic                w_wr;
    t_reg_idx            w_idx;
    logic [PRESET_W-1:0] r_preset;
    logic [PERIOD_W-1:0] r_period;

    assign w_wr  = i_psel & i_penable & i_pwrite;
    assign w_idx = t_reg_idx'(i_paddr[APB_ADDR_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= '0;
            r_period <= PERIOD_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PRESET: r_preset <= i_pwdata[PRESET_W-1:0];
                REG_PERIOD: r_period <= i_pwdata[PERIOD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PRESET: o_prdata = APB_DATA_W'(r_preset);
            REG_PERIOD: o_prdata = APB_DATA_W'(r_period);
        endcase
    end

    assign o_preset = r_preset;
    assign o_period = r_period;

endmodule

/* rtl/scdt_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
// 33 bit by 32 bit giving a 65 bit product; depends on scdt_pkg
module scdt_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [scdt_pkg::MULT_W-1:0]    i_mult,
    input  logic [scdt_pkg::PERIOD_W-1:0]  i_mcand,
    output logic [scdt_pkg::PERIOD_W-1:0]  o_prod_hi,
    output logic [scdt_pkg::MULT_W-1:0]    o_prod_lo,
    output scdt_pkg::t_unit_sts            o_sts
);
    import scdt_pkg::*;

    logic [PERIOD_W-1:0] r_hi;
    logic [MULT_W-1:0]   r_lo;
    logic [PERIOD_W-1:0] r_mcand;
    logic [STEP_W-1:0]   r_step;
    logic                r_busy;
    logic                r_done;
    logic [PERIOD_W:0]   w_sum;

    // add the multiplicand when the current multiplier bit is set
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi    <= '0;
            r_lo    <= i_mult;
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_hi <= w_sum[PERIOD_W:1];
            r_lo <= {w_sum[0], r_lo[MULT_W-1:1]};
        end
    end

    assign o_prod_hi = r_hi;
    assign o_prod_lo = r_lo;
    assign o_sts     = '{busy: r_busy, done: r_done};

endmodule

/* rtl/scdt_div.sv */
// restoring bit-serial divider, one quotient bit per cycle
// 33 bit dividend by 32 bit divisor; depends on scdt_pkg
module scdt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [scdt_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [scdt_pkg::PERIOD_W-1:0]  i_divisor,
    output logic [scdt_pkg::DIVD_W-1:0]    o_quotient,
    output scdt_pkg::t_unit_sts            o_sts
);
    import scdt_pkg::*;

    logic [PERIOD_W-1:0] r_rem;
    logic [DIVD_W-1:0]   r_quo;
    logic [PERIOD_W-1:0] r_dvs;
    logic [STEP_W-1:0]   r_step;
    logic                r_busy;
    logic                r_done;
    logic [PERIOD_W:0]   w_shift;
    logic [PERIOD_W+1:0] w_trial;
    logic                w_ge;

    // partial remainder stays below the divisor, so 32 bits hold it
    assign w_shift = {r_rem, r_quo[DIVD_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_trial[PERIOD_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_sts      = '{busy: r_busy, done: r_done};

endmodule

/* rtl/scan_count_on_delay_timer.sv */
// top level of the scan count on-delay timer: sequencer, timer state, result register
// depends on scdt_pkg, scdt_if, scdt_apb, scdt_mul and scdt_div
//
//   channel  dir  beat payload                  handshake
//   i_in     in   enable, scan_count[31:0]      valid/ready
//   o_out    out  done_res, elapsed_ms[22:0]    valid/ready
//   apb      in   preset_ms @0x0, scan_period_us @0x4   psel/penable/pwrite, pready=1
//
// one scan at a time; i_in.ready is high only while the sequencer is idle
// enable low, timer already done or count at the end count: EVAL goes straight to OUT
// rising edge: 33 step divider for preset*1000/period in TICKS
// timing scan: 33 step multiplier, then a 33 step divide by 1000 unless the product clamps
// sync active-low reset clears timer state, config to preset 0 / period 500000
// a result waiting on o_out does not block the next accept; the next one waits in ST_OUT
module scan_count_on_delay_timer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scdt_in_if.sink                          i_in,
    scdt_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scdt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [scdt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [scdt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import scdt_pkg::*;

    // config
    logic [PRESET_W-1:0] w_preset;
    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W-1:0] w_per_eff;

    // sequencer
    t_state r_state;
    t_state n_state;
    logic   w_div_start;
    logic   w_mul_start;
    logic   w_load_out;

    // captured scan
    logic               r_en;
    logic [COUNT_W-1:0] r_cnt;

    // timer state
    logic                r_prev_en;
    logic                r_done_flag;
    logic [PRESET_W-1:0] r_elapsed;
    logic [END_W-1:0]    r_end;

    // result register
    logic                r_out_valid;
    logic                r_out_done;
    logic [PRESET_W-1:0] r_out_elapsed;

    // serial units
    logic [DIVD_W-1:0]   w_div_dividend;
    logic [PERIOD_W-1:0] w_div_divisor;
    logic [DIVD_W-1:0]   w_div_quo;
    t_unit_sts           w_div_sts;
    logic [PERIOD_W-1:0] w_prod_hi;
    logic [MULT_W-1:0]   w_prod_lo;
    t_unit_sts           w_mul_sts;

    // compares
    logic             w_cnt_ge_end;
    logic             w_cnt_ge_end_lo;
    logic [END_W-1:0] w_remain;
    logic [END_W-1:0] w_limit;
    logic             w_clamp;

    scdt_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_preset  (w_preset),
        .o_period  (w_period)
    );
    assign pready = 1'b1;

    // a zero period counts as one microsecond
    assign w_per_eff = (w_period == '0) ? PERIOD_W'(1) : w_period;

    // divider serves two jobs: scans to run (in EVAL) and product to ms (in CHK)
    assign w_div_dividend = (r_state == ST_EVAL) ? ms_to_us(END_W'(w_preset)) : w_prod_lo;
    assign w_div_divisor  = (r_state == ST_EVAL) ? w_per_eff : US_PER_MS;

    scdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_quotient (w_div_quo),
        .o_sts      (w_div_sts)
    );

    // remaining scans times period gives remaining time in us
    assign w_remain = r_end - {1'b0, r_cnt};

    scdt_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mult    (w_remain),
        .i_mcand   (w_per_eff),
        .o_prod_hi (w_prod_hi),
        .o_prod_lo (w_prod_lo),
        .o_sts     (w_mul_sts)
    );

    assign w_cnt_ge_end    = {1'b0, r_cnt} >= r_end;
    assign w_cnt_ge_end_lo = r_cnt >= r_end[COUNT_W-1:0];

    // remaining ms above preset <=> product >= (preset+1)*1000; covers products wider than 33 bits too
    assign w_limit = ms_to_us(END_W'(w_preset) + END_W'(1));
    assign w_clamp = (w_prod_hi != '0) || (w_prod_lo >= w_limit);

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_en) begin
                    n_state = ST_OUT;
                end else if (!r_prev_en) begin
                    w_div_start = 1'b1;
                    n_state     = ST_TICKS;
                end else if (r_done_flag || w_cnt_ge_end) begin
                    n_state = ST_OUT;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = ST_MUL;
                end
            end
            ST_TICKS: begin
                if (w_div_sts.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL: begin
                if (w_mul_sts.done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (w_clamp) begin
                    n_state = ST_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIVMS;
                end
            end
            ST_DIVMS: begin
                if (w_div_sts.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // result register free or being emptied this cycle
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // capture the scan beat
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_en  <= i_in.enable;
            r_cnt <= i_in.scan_count;
        end
    end

    // timer state updates, one point per sequencer step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_en   <= 1'b0;
            r_done_flag <= 1'b0;
            r_elapsed   <= '0;
            r_end       <= '0;
        end else begin
            case (r_state)
                ST_EVAL: begin
                    if (!r_en) begin
                        r_done_flag <= 1'b0;
                        r_elapsed   <= '0;
                        r_end       <= '0;
                    end else if (!r_prev_en) begin
                        r_done_flag <= 1'b0;
                        r_elapsed   <= '0;
                    end else if (!r_done_flag && w_cnt_ge_end) begin
                        // count reached or passed end: saturate
                        r_elapsed   <= w_preset;
                        r_done_flag <= 1'b1;
                    end
                end
                ST_TICKS: begin
                    if (w_div_sts.done) begin
                        r_end <= {1'b0, r_cnt} + w_div_quo;
                    end
                end
                ST_CHK: begin
                    if (w_clamp) begin
                        r_elapsed   <= w_preset;
                        r_done_flag <= 1'b1;
                    end
                end
                ST_DIVMS: begin
                    if (w_div_sts.done) begin
                        // quotient is at most preset here, no wrap
                        r_elapsed <= w_preset - w_div_quo[PRESET_W-1:0];
                        // done checks only the low 32 bits of the end count
                        if (w_cnt_ge_end_lo) begin
                            r_done_flag <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_load_out) begin
                        r_prev_en <= r_en;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_done    <= r_done_flag;
            r_out_elapsed <= r_elapsed;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.done_res   = r_out_done;
    assign o_out.elapsed_ms = r_out_elapsed;

endmodule

/* rtl/scdt_chk.sv */
// port-level checker for the scan count on-delay timer, bound to the top level
// depends on scdt_pkg and the top level's ports
module scdt_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_done,
    input logic [scdt_pkg::PRESET_W-1:0]  i_out_elapsed
);
    import scdt_pkg::*;

    // after reset the block is idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("not idle after reset");

    // one scan at a time: an accepted beat drops ready in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second scan taken while busy");

    // a stalled result holds its beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_done)
            && $stable(i_out_elapsed))
        else $error("stalled result changed");

    // a result appears only while a scan is in flight, with ready already low
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without a scan in flight");

endmodule

bind scan_count_on_delay_timer scdt_chk u_scdt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_done    (o_out.done_res),
    .i_out_elapsed (o_out.elapsed_ms)
);

/* tb/tb_scan_count_on_delay_timer.sv */
`timescale 1ns / 100ps
// self-checking testbench of the scan count on-delay timer: directed scans, then random
// enable/count sequences under varying config and handshake pressure
// depends on scdt_pkg, scdt_if and the scan_count_on_delay_timer rtl
module tb_scan_count_on_delay_timer;
    import scdt_pkg::*;

    // no beat for this many cycles means the block is hung
    localparam int STALL_LIMIT  = 4000;
    // slowest scan runs the multiplier and then the divider, wait a bit past that at the end
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic                done;
        logic [PRESET_W-1:0] elapsed;
    } t_timer_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    scdt_in_if  scan_if ();
    scdt_out_if timer_if ();

    scan_count_on_delay_timer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (scan_if),
        .o_out   (timer_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // timer model state and its copy of the config registers
    logic                en_prev;
    logic                tmr_done;
    logic [PRESET_W-1:0] tmr_elapsed;
    logic [END_W-1:0]    tmr_end;
    logic [PRESET_W-1:0] cfg_preset;
    logic [PERIOD_W-1:0] cfg_period;

    t_timer_res expected_results[$];

    int fail_count   = 0;
    int stall_cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // one scan of the on-delay timer, returns the result beat it should produce
    function automatic t_timer_res timer_scan(input logic en, input logic [COUNT_W-1:0] cnt);
        logic [63:0]      per;
        logic [63:0]      ticks;
        logic [END_W-1:0] remain;
        logic [127:0]     remain_ms;
        t_timer_res       res;
        // a zero period counts as one microsecond
        per = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
        if (!en) begin
            tmr_done    = 1'b0;
            tmr_elapsed = '0;
            tmr_end     = '0;
        end else if (!en_prev) begin
            // rising edge: end count is now plus the preset in scans, kept to 33 bits
            ticks       = (64'(cfg_preset) * 64'(US_PER_MS)) / per;
            tmr_done    = 1'b0;
            tmr_elapsed = '0;
            tmr_end     = END_W'(64'(cnt) + ticks);
        end else if (!tmr_done) begin
            if ({1'b0, cnt} >= tmr_end) begin
                // count has passed the end: saturate instead of wrapping
                tmr_elapsed = cfg_preset;
                tmr_done    = 1'b1;
            end else begin
                // wide product so that a huge remaining time clamps as well
                remain    = tmr_end - {1'b0, cnt};
                remain_ms = (128'(remain) * 128'(per)) / 128'(US_PER_MS);
                if (remain_ms > 128'(cfg_preset)) begin
                    tmr_elapsed = cfg_preset;
                    tmr_done    = 1'b1;
                end else begin
                    tmr_elapsed = cfg_preset - PRESET_W'(remain_ms);
                end
            end
            // done looks at the low 32 bits of the end count only
            if (cnt >= tmr_end[COUNT_W-1:0]) tmr_done = 1'b1;
        end
        en_prev     = en;
        res.done    = tmr_done;
        res.elapsed = tmr_elapsed;
        return res;
    endfunction

    // receiver: stall at the falling edge with the phase's stall rate
    always @(negedge i_clk) begin
        timer_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // result checker: each output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_timer_res got;
        t_timer_res want;
        if (i_rst_n && timer_if.valid && timer_if.ready) begin
            got = {timer_if.done_res, timer_if.elapsed_ms};
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, actual done %0d elapsed %0d",
                         $time, got.done, got.elapsed);
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    fail_count++;
                    $display({"%0t: result mismatch, expected done %0d elapsed %0d,",
                              " actual done %0d elapsed %0d"},
                             $time, want.done, want.elapsed, got.done, got.elapsed);
                end
            end
        end
    end

    // watchdog: counts cycles in which no beat moves on any port
    always @(posedge i_clk) begin
        if ((scan_if.valid && scan_if.ready) || (timer_if.valid && timer_if.ready) ||
            (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // one scan beat; called at a falling edge, returns at the falling edge after accept
    // valid stays high on return so back-to-back beats need no extra edge
    task automatic send_scan(input logic en, input logic [COUNT_W-1:0] cnt);
        while ($urandom_range(99) < src_idle_pct) begin
            scan_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        scan_if.valid      <= 1'b1;
        scan_if.enable     <= en;
        scan_if.scan_count <= cnt;
        @(posedge i_clk);
        while (!scan_if.ready) @(posedge i_clk);
        expected_results.push_back(timer_scan(en, cnt));
        @(negedge i_clk);
    endtask

    // stop sending and wait until every result is back and the block is idle
    task automatic settle_idle();
        scan_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_timer_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_PRESET) begin
            cfg_preset = value[PRESET_W-1:0];
        end else begin
            cfg_period = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timer(input logic [PRESET_W-1:0] preset,
                             input logic [PERIOD_W-1:0] period);
        settle_idle();
        write_timer_reg(REG_PRESET, APB_DATA_W'(preset));
        write_timer_reg(REG_PERIOD, period);
    endtask

    // mostly presets of a few dozen scans, some fully random, some extremes
    task automatic pick_timer_config();
        logic [PRESET_W-1:0] preset;
        logic [PERIOD_W-1:0] period;
        int                  pick;
        int                  scans;
        pick = $urandom_range(9);
        if (pick < 6) begin
            preset = PRESET_W'($urandom_range(5000, 1));
            scans  = $urandom_range(40, 1);
            period = (32'(preset) * US_PER_MS) / 32'(scans) + $urandom_range(3);
        end else if (pick < 8) begin
            preset = PRESET_W'($urandom);
            period = $urandom;
        end else begin
            case ($urandom_range(2))
                0:       preset = '0;
                1:       preset = '1;
                default: preset = PRESET_W'(4294967);
            endcase
            case ($urandom_range(3))
                0:       period = '0;
                1:       period = 32'd1;
                2:       period = '1;
                default: period = PERIOD_RESET;
            endcase
        end
        set_timer(preset, period);
    endtask

    // well-formed timing runs with random counts, plus noise and runs cut short
    task automatic run_timer_sequences(input int n_items);
        int                  sent;
        int                  steps;
        int                  roll;
        logic [COUNT_W-1:0]  cnt;
        logic [END_W-1:0]    span;
        logic [END_W-1:0]    hop_w;
        logic [COUNT_W-1:0]  hop;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_scan(1'($urandom_range(1)), $urandom);
                sent++;
            end else begin
                // start near the 32 bit wrap now and then
                cnt = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(64) : $urandom;
                if ($urandom_range(1) == 1) begin
                    send_scan(1'b0, cnt);
                    sent++;
                end
                send_scan(1'b1, cnt);
                sent++;
                span  = tmr_end - {1'b0, cnt};
                hop_w = span / 3 + 1;
                hop   = (hop_w > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : hop_w[COUNT_W-1:0];
                steps = $urandom_range(8, 2);
                for (int s = 0; s < steps; s++) begin
                    roll = $urandom_range(99);
                    if (roll < 20) begin
                        // land just around the end count
                        cnt = tmr_end[COUNT_W-1:0] + $urandom_range(2) - 1;
                    end else if (roll < 25) begin
                        // count going backwards: remaining time above preset
                        cnt = cnt - $urandom_range(hop, 1);
                    end else begin
                        cnt = cnt + $urandom_range(hop);
                    end
                    send_scan(1'b1, cnt);
                    sent++;
                    if ($urandom_range(9) == 0) break;
                end
                if ($urandom_range(99) < 85) begin
                    send_scan(1'b0, $urandom);
                    sent++;
                end
            end
        end
    endtask

    // reset config: preset 0 expires on the scan after the edge
    task automatic test_reset_config();
        send_scan(1'b0, 32'd0);
        send_scan(1'b1, 32'd5);
        send_scan(1'b1, 32'd5);
        send_scan(1'b1, 32'hFFFF_FFFF);
        send_scan(1'b0, 32'hFFFF_FFFF);
    endtask

    // 100 ms at 10 ms per scan: partial elapsed, exact end, hold while done
    task automatic test_countdown();
        set_timer(PRESET_W'(100), 32'd10000);
        send_scan(1'b1, 32'd100);
        send_scan(1'b1, 32'd103);
        send_scan(1'b1, 32'd109);
        send_scan(1'b1, 32'd110);
        send_scan(1'b1, 32'd111);
        send_scan(1'b0, 32'd0);
    endtask

    // end count past 2^32: done comes early on the low 32 bits
    task automatic test_end_wrap();
        send_scan(1'b1, 32'hFFFF_FFFC);
        send_scan(1'b1, 32'hFFFF_FFFE);
        send_scan(1'b1, 32'd0);
        send_scan(1'b0, 32'd1);
    endtask

    // largest preset with a zero period, which counts as one microsecond
    task automatic test_extreme_presets();
        set_timer('1, '0);
        send_scan(1'b1, 32'd0);
        send_scan(1'b1, 32'd1);
        send_scan(1'b1, 32'hFFFF_FFFF);
        send_scan(1'b0, 32'd0);
    endtask

    // remaining time above preset clamps and sets done, also with the widest product
    task automatic test_clamp();
        set_timer(PRESET_W'(5000), 32'd1000000);
        send_scan(1'b1, 32'd1000);
        send_scan(1'b1, 32'd900);
        send_scan(1'b0, 32'd0);
        set_timer('1, '1);
        send_scan(1'b1, 32'hFFFF_FFFF);
        send_scan(1'b1, 32'd0);
        send_scan(1'b0, 32'd0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
        pick_timer_config();
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        run_timer_sequences(n_items);
    endtask

    initial begin
        scan_if.valid      = 1'b0;
        scan_if.enable     = 1'b0;
        scan_if.scan_count = '0;
        timer_if.ready     = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_rst_n            = 1'b0;
        cfg_preset         = '0;
        cfg_period         = PERIOD_RESET;
        en_prev            = 1'b0;
        tmr_done           = 1'b0;
        tmr_elapsed        = '0;
        tmr_end            = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_config();
        test_countdown();
        test_end_wrap();
        test_extreme_presets();
        test_clamp();

        // idling phases: none, sender gaps, receiver stalls, both; run twice
        for (int pass = 0; pass < 2; pass++) begin
            test_random_phase(0, 0, 68);
            test_random_phase(68, 0, 68);
            test_random_phase(0, 68, 68);
            test_random_phase(37, 37, 68);
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
